@@ rtl/opvc_pkg.sv @@
package opvc_pkg;

    localparam int SHARE_BITS = 13;
    localparam int SHARE_FRAC = 12;
    localparam int LVL_BITS   = 3;

    typedef logic [SHARE_BITS-1:0] share_t;
    typedef logic [LVL_BITS-1:0]   lvl_t;

    localparam share_t SHARE_UNIT = 13'd4096;

endpackage

@@ rtl/opvc_share.sv @@
module opvc_share #(
    parameter int ACC_BITS = 13
) (
    input  logic [ACC_BITS-1:0] acc,
    input  opvc_pkg::lvl_t      lvl,
    output opvc_pkg::share_t    share
);

    localparam int R = ACC_BITS + opvc_pkg::SHARE_FRAC + 1;

    logic [4:0]   sh3;
    logic [R-1:0] wide;
    logic [R-1:0] rnd;
    logic [R-1:0] shifted;

    // scale from 1/8^level units to 1/4096 units, round half up on fine levels
    always_comb
    begin
        sh3     = {2'b00, lvl} + {1'b0, lvl, 1'b0};
        wide    = {1'b0, acc, {opvc_pkg::SHARE_FRAC{1'b0}}};
        rnd     = (sh3 > 5'(opvc_pkg::SHARE_FRAC)) ? (R'(1) << (sh3 - 5'd1)) : '0;
        shifted = (wide + rnd) >> sh3;
        if (shifted > R'(opvc_pkg::SHARE_UNIT))
            share = opvc_pkg::SHARE_UNIT;
        else
            share = shifted[opvc_pkg::SHARE_BITS-1:0];
    end

endmodule

@@ rtl/octree_partial_volume_cube.sv @@
// Channel  Direction  Handshake              Payload
// cfg      in         cfg_we                 cfg_wdata (level)
// in       in         in_valid / in_ready    corner_x0y0z0 .. corner_x1y1z1
// out      out        out_valid / out_ready  share_x0y0z0 .. share_x1y1z1
//
// One item at a time; in_ready is high only while the sequencer is idle.
// The sequencer visits one grid point per cycle through the single shared
// add/sub unit, plus row, plane and edge stepping.
// A finished result waits in the output register; the next item is accepted
// meanwhile and its result holds in the final state until that register frees.
// rst_n clears the sequencer and sets the level register to 2.
module octree_partial_volume_cube #(
    parameter int MAX_LEVEL   = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  opvc_pkg::lvl_t                cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] corner_x0y0z0,
    input  logic signed [SAMPLE_BITS-1:0] corner_x1y0z0,
    input  logic signed [SAMPLE_BITS-1:0] corner_x0y1z0,
    input  logic signed [SAMPLE_BITS-1:0] corner_x1y1z0,
    input  logic signed [SAMPLE_BITS-1:0] corner_x0y0z1,
    input  logic signed [SAMPLE_BITS-1:0] corner_x1y0z1,
    input  logic signed [SAMPLE_BITS-1:0] corner_x0y1z1,
    input  logic signed [SAMPLE_BITS-1:0] corner_x1y1z1,
    output logic                          out_valid,
    input  logic                          out_ready,
    output opvc_pkg::share_t              share_x0y0z0,
    output opvc_pkg::share_t              share_x1y0z0,
    output opvc_pkg::share_t              share_x0y1z0,
    output opvc_pkg::share_t              share_x1y1z0,
    output opvc_pkg::share_t              share_x0y0z1,
    output opvc_pkg::share_t              share_x1y0z1,
    output opvc_pkg::share_t              share_x0y1z1,
    output opvc_pkg::share_t              share_x1y1z1
);

    localparam int W  = SAMPLE_BITS + 3 * MAX_LEVEL + 1;
    localparam int A  = 3 * MAX_LEVEL + 1;
    localparam int CW = MAX_LEVEL + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EDGE  = 3'd1;
    localparam logic [2:0] S_PLANE = 3'd2;
    localparam logic [2:0] S_ROW   = 3'd3;
    localparam logic [2:0] S_POINT = 3'd4;
    localparam logic [2:0] S_GSTEP = 3'd5;
    localparam logic [2:0] S_ESTEP = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    typedef logic signed [W-1:0]           wide_t;
    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [A-1:0]                  acc_t;
    typedef logic [CW-1:0]                 coord_t;

    logic [2:0]     state_reg, state_next;
    logic [1:0]     cnt_reg, cnt_next;
    coord_t         a_reg, a_next;
    coord_t         b_reg, b_next;
    coord_t         c_reg, c_next;
    opvc_pkg::lvl_t cfg_reg;
    opvc_pkg::lvl_t lvl_reg, lvl_next;
    logic           out_valid_reg, out_valid_next;

    sample_t cv_reg [8];
    sample_t cv_next [8];
    wide_t   e_reg [4];
    wide_t   e_next [4];
    wide_t   de_reg [4];
    wide_t   de_next [4];
    wide_t   g_reg [2];
    wide_t   g_next [2];
    wide_t   dg_reg [2];
    wide_t   dg_next [2];
    wide_t   v_reg, v_next;
    wide_t   dv_reg, dv_next;
    acc_t    acc_reg [8];
    acc_t    acc_next [8];

    opvc_pkg::share_t share_reg [8];
    opvc_pkg::share_t share_next [8];
    opvc_pkg::share_t share_calc [8];

    sample_t corner_in [8];

    wide_t          op_x, op_y, op_sum;
    logic           op_sub;
    opvc_pkg::lvl_t lvl_eff;
    coord_t         n_val, h_val;
    logic [1:0]     lo_a, lo_b, lo_c, hi_a, hi_b, hi_c;
    logic [3:0]     mult [8];
    logic [4:0]     sh3;
    acc_t           n_cube;

    function automatic wide_t sx(input sample_t s);
        sx = {{(W-SAMPLE_BITS){s[SAMPLE_BITS-1]}}, s};
    endfunction

    function automatic wide_t shl(input wide_t v, input opvc_pkg::lvl_t l);
        shl = v <<< l;
    endfunction

    // leaves in the lower / upper half that touch grid coordinate x
    function automatic logic [1:0] lo_cnt(input coord_t x, input coord_t h);
        lo_cnt = {1'b0, (x != '0) && (x <= h)} + {1'b0, x < h};
    endfunction

    function automatic logic [1:0] hi_cnt(input coord_t x, input coord_t h, input coord_t n);
        hi_cnt = {1'b0, x > h} + {1'b0, (x >= h) && (x < n)};
    endfunction

    assign corner_in[0] = corner_x0y0z0;
    assign corner_in[1] = corner_x1y0z0;
    assign corner_in[2] = corner_x0y1z0;
    assign corner_in[3] = corner_x1y1z0;
    assign corner_in[4] = corner_x0y0z1;
    assign corner_in[5] = corner_x1y0z1;
    assign corner_in[6] = corner_x0y1z1;
    assign corner_in[7] = corner_x1y1z1;

    assign lvl_eff = (cfg_reg > opvc_pkg::lvl_t'(MAX_LEVEL)) ?
                     opvc_pkg::lvl_t'(MAX_LEVEL) : cfg_reg;
    assign n_val   = coord_t'(1) << lvl_reg;
    assign h_val   = n_val >> 1;
    assign sh3     = {2'b00, lvl_reg} + {1'b0, lvl_reg, 1'b0};
    assign n_cube  = acc_t'(1) << sh3;

    assign lo_a = lo_cnt(a_reg, h_val);
    assign lo_b = lo_cnt(b_reg, h_val);
    assign lo_c = lo_cnt(c_reg, h_val);
    assign hi_a = hi_cnt(a_reg, h_val, n_val);
    assign hi_b = hi_cnt(b_reg, h_val, n_val);
    assign hi_c = hi_cnt(c_reg, h_val, n_val);

    always_comb
    begin
        logic [3:0] mx, my, mz;
        for (int o = 0; o < 8; o++)
        begin
            mx = {2'b00, (o[0] ? hi_a : lo_a)};
            my = {2'b00, (o[1] ? hi_b : lo_b)};
            mz = {2'b00, (o[2] ? hi_c : lo_c)};
            mult[o] = mx * my * mz;
        end
    end

    // operand select for the shared add/sub unit
    always_comb
    begin
        op_x   = '0;
        op_y   = '0;
        op_sub = 1'b0;
        case (state_reg)
            S_EDGE:
            begin
                op_x   = sx(cv_reg[4]);
                op_y   = sx(cv_reg[0]);
                op_sub = 1'b1;
            end
            S_PLANE:
            begin
                op_x   = cnt_reg[0] ? e_reg[3] : e_reg[2];
                op_y   = cnt_reg[0] ? e_reg[1] : e_reg[0];
                op_sub = 1'b1;
            end
            S_ROW:
            begin
                op_x   = g_reg[1];
                op_y   = g_reg[0];
                op_sub = 1'b1;
            end
            S_POINT:
            begin
                op_x = v_reg;
                op_y = dv_reg;
            end
            S_GSTEP:
            begin
                op_x = cnt_reg[0] ? g_reg[1] : g_reg[0];
                op_y = cnt_reg[0] ? dg_reg[1] : dg_reg[0];
            end
            S_ESTEP:
            begin
                op_x = e_reg[0];
                op_y = de_reg[0];
            end
            default:
            begin
                op_sub = 1'b0;
            end
        endcase
    end

    // shared add/sub unit
    assign op_sum = op_sub ? (op_x - op_y) : (op_x + op_y);

    genvar gi;
    generate
        for (gi = 0; gi < 8; gi++)
        begin : g_share
            opvc_share #(
                .ACC_BITS(A)
            ) u_share (
                .acc  (acc_reg[gi]),
                .lvl  (lvl_reg),
                .share(share_calc[gi])
            );
        end
    endgenerate

    always_comb
    begin
        logic [A+3:0] acc_sum;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg;
        cv_next        = cv_reg;
        e_next         = e_reg;
        de_next        = de_reg;
        g_next         = g_reg;
        dg_next        = dg_reg;
        v_next         = v_reg;
        dv_next        = dv_reg;
        acc_next       = acc_reg;
        share_next     = share_reg;
        acc_sum        = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cv_next  = corner_in;
                    lvl_next = lvl_eff;
                    // level zero: each non-negative corner takes its whole octant
                    for (int k = 0; k < 8; k++)
                        acc_next[k] = (lvl_eff == '0) ?
                                      acc_t'(!corner_in[k][SAMPLE_BITS-1]) : '0;
                    cnt_next = '0;
                    a_next   = '0;
                    b_next   = '0;
                    c_next   = '0;
                    state_next = (lvl_eff == '0) ? S_FIN : S_EDGE;
                end
            end
            S_EDGE:
            begin
                // edge slopes along z; corner groups rotate past slot 0
                for (int k = 0; k < 3; k++)
                begin
                    cv_next[k]     = cv_reg[k+1];
                    cv_next[k+4]   = cv_reg[k+5];
                    de_next[k]     = de_reg[k+1];
                    e_next[k]      = e_reg[k+1];
                end
                cv_next[3] = cv_reg[0];
                cv_next[7] = cv_reg[4];
                de_next[3] = op_sum;
                e_next[3]  = shl(sx(cv_reg[0]), lvl_reg);
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    state_next = S_PLANE;
            end
            S_PLANE:
            begin
                if (cnt_reg[0])
                begin
                    dg_next[1] = op_sum;
                    g_next[1]  = shl(e_reg[1], lvl_reg);
                    cnt_next   = '0;
                    state_next = S_ROW;
                end
                else
                begin
                    dg_next[0] = op_sum;
                    g_next[0]  = shl(e_reg[0], lvl_reg);
                    cnt_next   = 2'd1;
                end
            end
            S_ROW:
            begin
                dv_next    = op_sum;
                v_next     = shl(g_reg[0], lvl_reg);
                a_next     = '0;
                state_next = S_POINT;
            end
            S_POINT:
            begin
                if (!v_reg[W-1])
                begin
                    for (int o = 0; o < 8; o++)
                    begin
                        acc_sum     = {4'b0000, acc_reg[o]} + {{A{1'b0}}, mult[o]};
                        acc_next[o] = acc_sum[A-1:0];
                    end
                end
                if (a_reg != n_val)
                begin
                    v_next = op_sum;
                    a_next = a_reg + coord_t'(1);
                end
                else if (b_reg != n_val)
                begin
                    cnt_next   = '0;
                    state_next = S_GSTEP;
                end
                else if (c_reg != n_val)
                begin
                    cnt_next   = '0;
                    state_next = S_ESTEP;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_GSTEP:
            begin
                if (cnt_reg[0])
                begin
                    g_next[1]  = op_sum;
                    b_next     = b_reg + coord_t'(1);
                    cnt_next   = '0;
                    state_next = S_ROW;
                end
                else
                begin
                    g_next[0] = op_sum;
                    cnt_next  = 2'd1;
                end
            end
            S_ESTEP:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    e_next[k]  = e_reg[k+1];
                    de_next[k] = de_reg[k+1];
                end
                e_next[3]  = op_sum;
                de_next[3] = de_reg[0];
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    c_next     = c_reg + coord_t'(1);
                    b_next     = '0;
                    state_next = S_PLANE;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    share_next     = share_calc;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            lvl_reg       <= '0;
            cfg_reg       <= 3'd2;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            c_reg         <= c_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                cfg_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        cv_reg    <= cv_next;
        e_reg     <= e_next;
        de_reg    <= de_next;
        g_reg     <= g_next;
        dg_reg    <= dg_next;
        v_reg     <= v_next;
        dv_reg    <= dv_next;
        acc_reg   <= acc_next;
        share_reg <= share_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign share_x0y0z0 = share_reg[0];
    assign share_x1y0z0 = share_reg[1];
    assign share_x0y1z0 = share_reg[2];
    assign share_x1y1z0 = share_reg[3];
    assign share_x0y0z1 = share_reg[4];
    assign share_x1y0z1 = share_reg[5];
    assign share_x0y1z1 = share_reg[6];
    assign share_x1y1z1 = share_reg[7];

    a_grid_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POINT) |-> (a_reg <= n_val && b_reg <= n_val && c_reg <= n_val))
        else $error("grid coordinate out of range");

    a_start_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && lvl_eff != '0) |=> (state_reg == S_EDGE))
        else $error("accepted item did not start edge setup");

    a_acc_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |-> (acc_reg[0] <= n_cube))
        else $error("octant count exceeds leaf corner total");

    a_share_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (share_x0y0z0 <= opvc_pkg::SHARE_UNIT &&
                       share_x1y1z1 <= opvc_pkg::SHARE_UNIT))
        else $error("share above full octant volume");

endmodule
